// File: hdl/http_response_header_parser_core_macros.svh
// Assertion macros used by the HTTP response parser checker.
`ifndef HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/hrp_pkg.sv
// Package: codes, character constants and transaction types of the HTTP response parser.
`default_nettype none
package hrp_pkg;

	localparam int STATUS_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 32;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	localparam logic [1:0] RES_CONTENT = 2'd0;
	localparam logic [1:0] RES_DONE    = 2'd1;
	localparam logic [1:0] RES_ERROR   = 2'd2;

	typedef enum logic [2:0] {
		PH_PRE_STATUS = 3'd0,
		PH_STATUS     = 3'd1,
		PH_HEADER     = 3'd2,
		PH_CR         = 3'd3,
		PH_CRLF       = 3'd4,
		PH_CRLFCR     = 3'd5,
		PH_BODY       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		RUN_ACTIVE   = 2'd0,
		RUN_FINISHED = 2'd1
	} run_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  content;
		logic [15:0] status;
		logic [31:0] length;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/hrp_in_stage.sv
// Input register stage: holds one accepted transaction until the parser takes it.
`default_nettype none
module hrp_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire hrp_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output hrp_pkg::item_t     item_s1
);
	import hrp_pkg::*;

	// Refill whenever the stage is empty or drains this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// File: hdl/hrp_parse.sv
// Parser core: phase machine, status accumulator and body counter.
`default_nettype none
module hrp_parse #(
	parameter int STATUS_BITS = hrp_pkg::STATUS_BITS_DEF,
	parameter int COUNT_BITS  = hrp_pkg::COUNT_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire hrp_pkg::item_t item_s1,
	output logic                res_valid,
	output hrp_pkg::result_t    res
);
	import hrp_pkg::*;

	phase_t                 phase_q, phase_d;
	run_t                   run_q, run_d;
	logic [STATUS_BITS-1:0] status_q, status_d;
	logic [COUNT_BITS-1:0]  count_q, count_d;

	logic [7:0]             ch;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [7:0]             digit_full;
	logic [STATUS_BITS+3:0] status_ext;
	logic [STATUS_BITS+3:0] status_x10;

	assign ch         = item_s1.data;
	assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit_full = ch - CH_ZERO;
	assign digit      = digit_full[3:0];
	assign status_ext = {4'b0000, status_q};
	// times ten plus digit; the top four bits flag overflow
	assign status_x10 = (status_ext << 3) + (status_ext << 1)
	                    + (STATUS_BITS+4)'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PRE_STATUS;
			run_q    <= RUN_ACTIVE;
			status_q <= '0;
			count_q  <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			run_q    <= run_d;
			status_q <= status_d;
			count_q  <= count_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		run_d     = run_q;
		status_d  = status_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '0;
		priority if (item_s1.kind == KIND_RESTART) begin
			phase_d  = PH_PRE_STATUS;
			run_d    = RUN_ACTIVE;
			status_d = '0;
			count_d  = '0;
		end else if (item_s1.kind == KIND_UNUSED || run_q != RUN_ACTIVE) begin
			// drop
		end else if (item_s1.kind == KIND_END) begin
			res_valid  = 1'b1;
			res.kind   = RES_DONE;
			res.status = 16'(status_q);
			res.length = 32'(count_q);
			run_d      = RUN_FINISHED;
		end else begin
			unique case (phase_q)
				PH_PRE_STATUS: begin
					if (ch == CH_SPACE) phase_d = PH_STATUS;
				end
				PH_STATUS: begin
					if (ch == CH_SPACE) begin
						phase_d = PH_HEADER;
					end else if (!is_digit) begin
						res_valid = 1'b1;
						res.kind  = RES_ERROR;
						run_d     = RUN_FINISHED;
					end else if (status_x10[STATUS_BITS+3:STATUS_BITS] != 4'b0000) begin
						status_d = '1;
					end else begin
						status_d = status_x10[STATUS_BITS-1:0];
					end
				end
				PH_HEADER: begin
					if (ch == CH_CR) phase_d = PH_CR;
				end
				PH_CR: begin
					if (ch == CH_LF) phase_d = PH_CRLF;
					else if (ch != CH_CR) phase_d = PH_HEADER;
				end
				PH_CRLF: begin
					phase_d = (ch == CH_CR) ? PH_CRLFCR : PH_HEADER;
				end
				PH_CRLFCR: begin
					if (ch == CH_LF) phase_d = PH_BODY;
					else if (ch == CH_CR) phase_d = PH_CR;
					else phase_d = PH_HEADER;
				end
				PH_BODY: begin
					if (count_q != '1) count_d = count_q + COUNT_BITS'(1);
					res_valid   = 1'b1;
					res.kind    = RES_CONTENT;
					res.content = ch;
				end
				default: begin
					phase_d = PH_PRE_STATUS;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/hrp_out_stage.sv
// Output register: holds one result transaction until the consumer takes it.
`default_nettype none
module hrp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             res_valid,
	input  wire hrp_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output hrp_pkg::result_t      out_res
);
	import hrp_pkg::*;

	// advance is only raised when this register is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res <= res;
		end
	end

endmodule
`default_nettype wire

// File: hdl/http_response_header_parser_core.sv
// Top level of the HTTP response status line and header end parser.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------------
//   input   | in_valid/in_ready  | kind, data_byte
//   output  | out_valid/out_ready| result_kind, content_byte, status_code, body_length
//
// One transaction per cycle sustained while out_ready stays high; an accepted transaction
// is held in the input register, then parsed into the output register.
// The throughput is set by the combinational phase update and multiply-by-ten add.
// arst_n clears the phase machine, status, body count, run state and both valids.
// A result waiting at the output stalls the parse step only; one more transaction
// is still taken into the input register. Items that produce no result never
// occupy the output register.
`default_nettype none
module http_response_header_parser_core #(
	parameter int STATUS_BITS = hrp_pkg::STATUS_BITS_DEF,
	parameter int COUNT_BITS  = hrp_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       content_byte,
	output logic [15:0]      status_code,
	output logic [31:0]      body_length
);
	import hrp_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_item.kind = kind;
	assign in_item.data = data_byte;

	// Parse the held transaction when the output register can take its result.
	assign advance = valid_s1 && (!out_valid || out_ready);

	hrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hrp_parse #(
		.STATUS_BITS (STATUS_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	hrp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign result_kind  = out_res.kind;
	assign content_byte = out_res.content;
	assign status_code  = out_res.status;
	assign body_length  = out_res.length;

endmodule
`default_nettype wire

// File: hdl/hrp_checker.sv
// Port-level checker for the HTTP response parser, bound to the top level.
`default_nettype none
`include "http_response_header_parser_core_macros.svh"
module hrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  data_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  result_kind,
	input wire logic [7:0]  content_byte,
	input wire logic [15:0] status_code,
	input wire logic [31:0] body_length
);
	import hrp_pkg::*;

	`HRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(content_byte) && $stable(status_code) && $stable(body_length), "output transaction changed while stalled")
	`HRP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
	`HRP_ASSERT_NOW(a_content_clean, out_valid && result_kind != RES_CONTENT, content_byte == 8'd0, "content byte set outside content result")
	`HRP_ASSERT_NOW(a_done_fields, out_valid && result_kind != RES_DONE, status_code == 16'd0 && body_length == 32'd0, "status or length set outside completion")

endmodule

bind http_response_header_parser_core hrp_checker u_hrp_checker (.*);
`default_nettype wire
